>>> rtl/iir_df_pkg.sv
`default_nettype none

package iir_df_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int NUM_B     = 4;
    localparam int NUM_A     = 3;
    localparam int B_IDX_W   = 2;
    localparam int A_IDX_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 3;

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TERM_COUNT = 3'd0,
        CFG_COEF_B0    = 3'd1,
        CFG_COEF_B1    = 3'd2,
        CFG_COEF_B2    = 3'd3,
        CFG_COEF_B3    = 3'd4,
        CFG_COEF_A0    = 3'd5,
        CFG_COEF_A1    = 3'd6,
        CFG_COEF_A2    = 3'd7
    } cfg_index_t;

endpackage

`default_nettype wire

>>> rtl/iir_filter_direct_form.sv
`default_nettype none

// Direct form I filter, up to MAX_TERMS terms, signed Q(32-FRAC_BITS).FRAC_BITS samples.
// Takes one sample per clock cycle unless m_axis back-pressure stalls it; each result
// passes through the input register and then the result register before it is on m_axis.
// All taps and feedback products are formed in one combinational pass over the input
// register and the history shift lines, so the feedback loop closes through the y
// history register alone. Products are floored by FRAC_BITS, summed exactly and
// saturated to 32 bits (flag on tuser).
// term_count of 0 gives output 0; counts above MAX_TERMS act as MAX_TERMS.
// Write configuration only while the block is idle.
module iir_filter_direct_form #(
    parameter int MAX_TERMS = 4,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [iir_df_pkg::DATA_W-1:0]       s_axis_tdata,  // [31:0] sample_in
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [iir_df_pkg::DATA_W-1:0]            m_axis_tdata,  // [31:0] filtered_out
    output logic                                     m_axis_tuser,  // [0] saturated
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [iir_df_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [iir_df_pkg::DATA_W-1:0]       cfg_data
);

    localparam int HIST_D = (MAX_TERMS > 1) ? MAX_TERMS - 1 : 1;
    localparam int N_W    = $clog2(MAX_TERMS + 1) + 1;
    localparam int ACC_W  = iir_df_pkg::PROD_W - FRAC_BITS + $clog2(2 * MAX_TERMS) + 1;
    localparam int DW     = iir_df_pkg::DATA_W;

    logic [iir_df_pkg::COUNT_W-1:0] term_count_reg;
    iir_df_pkg::sample_t            coef_b_reg [iir_df_pkg::NUM_B];
    iir_df_pkg::sample_t            coef_a_reg [iir_df_pkg::NUM_A];

    iir_df_pkg::sample_t            x_hist_reg [HIST_D];
    iir_df_pkg::sample_t            y_hist_reg [HIST_D];

    logic                           in_valid_reg;
    iir_df_pkg::sample_t            in_sample_reg;
    logic                           out_valid_reg;
    logic [DW-1:0]                  out_data_reg;
    logic                           out_sat_reg;

    logic                           advance;
    logic [DW-1:0]                  y_next;
    logic                           sat_next;
    logic signed [ACC_W-1:0]        acc;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_sat_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= '0;
            for (int i = 0; i < iir_df_pkg::NUM_B; i++)
            begin
                coef_b_reg[i] <= '0;
            end
            for (int i = 0; i < iir_df_pkg::NUM_A; i++)
            begin
                coef_a_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            case (iir_df_pkg::cfg_index_t'(cfg_index))
                iir_df_pkg::CFG_TERM_COUNT: term_count_reg <= cfg_data[iir_df_pkg::COUNT_W-1:0];
                iir_df_pkg::CFG_COEF_B0:    coef_b_reg[0]  <= cfg_data;
                iir_df_pkg::CFG_COEF_B1:    coef_b_reg[1]  <= cfg_data;
                iir_df_pkg::CFG_COEF_B2:    coef_b_reg[2]  <= cfg_data;
                iir_df_pkg::CFG_COEF_B3:    coef_b_reg[3]  <= cfg_data;
                iir_df_pkg::CFG_COEF_A0:    coef_a_reg[0]  <= cfg_data;
                iir_df_pkg::CFG_COEF_A1:    coef_a_reg[1]  <= cfg_data;
                iir_df_pkg::CFG_COEF_A2:    coef_a_reg[2]  <= cfg_data;
                default:                    term_count_reg <= term_count_reg;
            endcase
        end
    end

    // multiply-accumulate over all taps
    always_comb
    begin
        logic [N_W-1:0]           n;
        logic [N_W-1:0]           ci;
        iir_df_pkg::sample_t      cb;
        iir_df_pkg::sample_t      ca;
        iir_df_pkg::sample_t      xt;
        logic signed [iir_df_pkg::PROD_W-1:0] pb;
        logic signed [iir_df_pkg::PROD_W-1:0] pa;
        logic                     fits;

        if (N_W'(term_count_reg) > N_W'(MAX_TERMS))
        begin
            n = N_W'(MAX_TERMS);
        end
        else
        begin
            n = N_W'(term_count_reg);
        end
        acc = '0;
        for (int k = 0; k < MAX_TERMS; k++)
        begin
            ci = n - N_W'(k + 1);
            cb = '0;
            ca = '0;
            if (N_W'(k) < n)
            begin
                if (ci < N_W'(iir_df_pkg::NUM_B))
                begin
                    cb = coef_b_reg[ci[iir_df_pkg::B_IDX_W-1:0]];
                end
                if (ci < N_W'(iir_df_pkg::NUM_A))
                begin
                    ca = coef_a_reg[ci[iir_df_pkg::A_IDX_W-1:0]];
                end
            end
            xt = (k == 0) ? in_sample_reg : x_hist_reg[(k == 0) ? 0 : k - 1];
            pb = cb * xt;
            acc = acc + ACC_W'(pb >>> FRAC_BITS);
            if (k >= 1)
            begin
                pa = ca * y_hist_reg[k - 1];
                acc = acc - ACC_W'(pa >>> FRAC_BITS);
            end
        end
        fits = (acc[ACC_W-1:DW-1] == '0) || (acc[ACC_W-1:DW-1] == '1);
        sat_next = !fits;
        if (fits)
        begin
            y_next = acc[DW-1:0];
        end
        else if (acc[ACC_W-1])
        begin
            y_next = {1'b1, {(DW-1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(DW-1){1'b1}}};
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < HIST_D; j++)
            begin
                x_hist_reg[j] <= '0;
                y_hist_reg[j] <= '0;
            end
        end
        else if (advance)
        begin
            x_hist_reg[0] <= in_sample_reg;
            y_hist_reg[0] <= y_next;
            for (int j = 1; j < HIST_D; j++)
            begin
                x_hist_reg[j] <= x_hist_reg[j - 1];
                y_hist_reg[j] <= y_hist_reg[j - 1];
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_sample_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_data_reg <= y_next;
            out_sat_reg  <= sat_next;
        end
    end

endmodule

`default_nettype wire
